FILE: src/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Shared types, function codes, limits and the byte-wide CRC-16 update used
// by the front and back parts of the checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    // Longest frame accepted and largest quantity a read may ask for.
    localparam int unsigned MAX_FRAME     = 256;
    localparam int unsigned MAX_READ_BITS = 2000;

    localparam int unsigned LEN_W = 9;

    // Function codes and the exception flag.
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [7:0] FN_READ_LAST   = 8'h04;
    localparam logic [7:0] FN_WRITE_COIL  = 8'h05;
    localparam logic [7:0] FN_WRITE_REG   = 8'h06;
    localparam logic [7:0] FN_READ_COILS  = 8'h01;
    localparam logic [7:0] FN_READ_INPUTS = 8'h02;
    localparam logic [7:0] FN_READ_HOLD   = 8'h03;
    localparam logic [7:0] FN_READ_INREG  = 8'h04;
    localparam logic [7:0] FN_WRITE_COILS = 8'h0F;
    localparam logic [7:0] FN_WRITE_REGS  = 8'h10;
    localparam logic [7:0] FN_REPORT_ID   = 8'h11;
    localparam logic [7:0] FN_MASK_WRITE  = 8'h16;
    localparam logic [7:0] FN_WRITE_READ  = 8'h17;

    // Configuration register indexes.
    localparam logic [2:0] REG_READY    = 3'd0;
    localparam logic [2:0] REG_SLAVE    = 3'd1;
    localparam logic [2:0] REG_FUNCTION = 3'd2;
    localparam logic [2:0] REG_WORD_A   = 3'd3;
    localparam logic [2:0] REG_WORD_B   = 3'd4;
    localparam logic [2:0] REG_WORD_C   = 3'd5;
    localparam logic [2:0] REG_QUANTITY = 3'd6;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_REQUEST  = 3'd1,
        ST_BAD_RESP    = 3'd2,
        ST_BAD_CRC     = 3'd3,
        ST_WRONG_SLAVE = 3'd4,
        ST_EXCEPTION   = 3'd5,
        ST_WRONG_FUNC  = 3'd6
    } t_status;

    // Request context held in configuration.
    typedef struct packed {
        logic        ready;
        logic [7:0]  slave;
        logic [7:0]  func;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [10:0] quantity;
    } t_cfg;

    // What the front part knows about a finished frame.
    typedef struct packed {
        logic             crc_zero;
        logic [LEN_W-1:0] len;
        logic [7:0]       slave;
        logic [7:0]       func;
        logic [7:0]       count_byte;
        logic             mism_low;
        logic             mism_high;
    } t_frame_sum;

    // One byte through the reflected CRC-16 (polynomial 0xA001).
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ 16'hA001;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

FILE: src/mrrc_front.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker front part
// Takes response bytes, runs the CRC, counts bytes, captures the header and
// compares echoed bytes; on the last byte it pushes a frame summary.
// ----------------------------------------------------------------------------
module mrrc_front
    import mrrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_last_byte,
    input  t_cfg       i_cfg,
    input  logic       i_q_full,
    output logic       o_in_stall,
    output logic       o_push,
    output t_frame_sum o_sum
);

    logic [15:0]      r_crc,   n_crc;
    logic [LEN_W-1:0] r_count, n_count;
    logic [7:0]       r_slave, n_slave;
    logic [7:0]       r_func,  n_func;
    logic [7:0]       r_cbyte, n_cbyte;
    logic             r_mlow,  n_mlow;
    logic             r_mhigh, n_mhigh;

    logic       accept;
    logic [7:0] want;
    logic       has_want;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid & ~i_q_full;
    assign o_push     = accept & i_last_byte;

    always_comb begin
        want     = 8'h00;
        has_want = 1'b1;
        case (r_count)
            9'd2:    want = i_cfg.word_a[15:8];
            9'd3:    want = i_cfg.word_a[7:0];
            9'd4:    want = i_cfg.word_b[15:8];
            9'd5:    want = i_cfg.word_b[7:0];
            9'd6:    want = i_cfg.word_c[15:8];
            9'd7:    want = i_cfg.word_c[7:0];
            default: has_want = 1'b0;
        endcase
    end

    always_comb begin
        n_crc   = crc16_byte(r_crc, i_rx_byte);
        n_slave = (r_count == 9'd0) ? i_rx_byte : r_slave;
        n_func  = (r_count == 9'd1) ? i_rx_byte : r_func;
        n_cbyte = (r_count == 9'd2) ? i_rx_byte : r_cbyte;
        n_mlow  = r_mlow;
        n_mhigh = r_mhigh;
        if (has_want && (want != i_rx_byte)) begin
            if (r_count <= 9'd5) begin
                n_mlow = 1'b1;
            end else begin
                n_mhigh = 1'b1;
            end
        end
        // The counter stops one above the longest legal frame.
        if (r_count < LEN_W'(MAX_FRAME + 1)) begin
            n_count = r_count + 9'd1;
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        o_sum.crc_zero   = (n_crc == 16'h0000);
        o_sum.len        = n_count;
        o_sum.slave      = n_slave;
        o_sum.func       = n_func;
        o_sum.count_byte = n_cbyte;
        o_sum.mism_low   = n_mlow;
        o_sum.mism_high  = n_mhigh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_crc   <= 16'hFFFF;
            r_count <= '0;
            r_slave <= '0;
            r_func  <= '0;
            r_cbyte <= '0;
            r_mlow  <= 1'b0;
            r_mhigh <= 1'b0;
        end else if (accept) begin
            r_crc   <= n_crc;
            r_count <= n_count;
            r_slave <= n_slave;
            r_func  <= n_func;
            r_cbyte <= n_cbyte;
            r_mlow  <= n_mlow;
            r_mhigh <= n_mhigh;
        end
    end

endmodule

FILE: src/mrrc_queue.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker summary queue
// Two-entry queue of frame summaries between the front and back parts.
// ----------------------------------------------------------------------------
module mrrc_queue
    import mrrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_sum i_data,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_frame_sum o_data
);

    t_frame_sum r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

FILE: src/mrrc_back.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker back part
// Judges one frame summary against the request and holds the verdict in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module mrrc_back
    import mrrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_empty,
    input  t_frame_sum       i_sum,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [7:0]       o_exception_code,
    output logic [LEN_W-1:0] o_frame_length
);

    logic             r_valid;
    t_status          r_status, n_status;
    logic [7:0]       r_exc,    n_exc;
    logic [LEN_W-1:0] r_len;

    logic             load;
    logic             read_form;
    logic             echo_form;
    logic             len_ok;
    logic [LEN_W-1:0] read_len;
    logic [11:0]      bit_bytes;
    logic [11:0]      reg_bytes;
    logic             qty_big;

    assign load  = ~r_valid | ~i_out_stall;
    assign o_pop = load & ~i_q_empty;

    always_comb begin
        read_form = (i_cfg.func <= FN_READ_LAST) || (i_cfg.func == FN_REPORT_ID)
                    || (i_cfg.func == FN_WRITE_READ);
        echo_form = (i_cfg.func == FN_WRITE_COIL) || (i_cfg.func == FN_WRITE_REG)
                    || (i_cfg.func == FN_WRITE_COILS) || (i_cfg.func == FN_WRITE_REGS);
        read_len  = {1'b0, i_sum.count_byte} + 9'd5;
        if (read_form) begin
            len_ok = (i_sum.len == read_len);
        end else if (echo_form) begin
            len_ok = (i_sum.len == 9'd8);
        end else begin
            len_ok = (i_cfg.func == FN_MASK_WRITE) && (i_sum.len == 9'd10);
        end
        bit_bytes = ({1'b0, i_cfg.quantity} + 12'd7) >> 3;
        reg_bytes = {i_cfg.quantity, 1'b0};
        qty_big   = ({21'd0, i_cfg.quantity} > 32'(MAX_READ_BITS));
    end

    always_comb begin
        n_exc    = 8'h00;
        n_status = ST_OK;
        if (!i_cfg.ready) begin
            n_status = ST_NO_REQUEST;
        end else if ((i_sum.len < 9'd5) || (i_sum.len > LEN_W'(MAX_FRAME))) begin
            n_status = ST_BAD_RESP;
        end else if (!i_sum.crc_zero) begin
            n_status = ST_BAD_CRC;
        end else if ((i_cfg.slave != 8'h00) && (i_sum.slave != i_cfg.slave)) begin
            n_status = ST_WRONG_SLAVE;
        end else if (i_sum.func == (i_cfg.func | EXC_FLAG)) begin
            if (i_sum.len != 9'd5) begin
                n_status = ST_BAD_RESP;
            end else begin
                n_status = ST_EXCEPTION;
                n_exc    = i_sum.count_byte;
            end
        end else if (i_sum.func != i_cfg.func) begin
            n_status = ST_WRONG_FUNC;
        end else if (!len_ok) begin
            n_status = ST_BAD_RESP;
        end else if ((i_cfg.func == FN_READ_COILS) || (i_cfg.func == FN_READ_INPUTS)) begin
            if (qty_big || ({4'd0, i_sum.count_byte} != bit_bytes)) begin
                n_status = ST_BAD_RESP;
            end
        end else if ((i_cfg.func == FN_READ_HOLD) || (i_cfg.func == FN_READ_INREG)
                     || (i_cfg.func == FN_WRITE_READ)) begin
            if (qty_big || ({4'd0, i_sum.count_byte} != reg_bytes)) begin
                n_status = ST_BAD_RESP;
            end
        end else if (echo_form) begin
            if (i_sum.mism_low) begin
                n_status = ST_BAD_RESP;
            end
        end else if (i_cfg.func == FN_MASK_WRITE) begin
            if (i_sum.mism_low || i_sum.mism_high) begin
                n_status = ST_BAD_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= ~i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_exc    <= n_exc;
            r_len    <= i_sum.len;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_status         = r_status;
    assign o_exception_code = r_exc;
    assign o_frame_length   = r_len;

endmodule

FILE: src/modbus_rtu_response_checker_top.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Master-side validation of one Modbus RTU response frame against the
// request context held in configuration registers.
// ----------------------------------------------------------------------------
// The block takes one response byte per cycle on the input channel when it
// is not stalled, with a flag on the final byte of each frame, and gives
// exactly one word on the output channel for each frame: a status, the
// exception code of an exception reply (zero otherwise) and the frame
// length, which saturates at one above the longest legal frame. Frames
// stream back to back at one byte per clock while the input is not stalled;
// the byte-wide CRC-16 update in the front part is the longest path. The
// summary of a frame is registered in a queue entry, and its verdict then in
// the output register. A two-entry queue of frame summaries sits between the
// byte front end and the judging back end, so a stalled output only holds
// off input bytes once the output register and both queue entries hold
// finished frames. Configuration registers should be written only while no
// frame is in progress and no verdict is outstanding; register indexes
// beyond the last one are ignored.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_top
    import mrrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_byte,
    // Verdict output channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic [8:0]  o_frame_length,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // The request context, written through the configuration port.
    t_cfg       r_cfg;

    logic       q_full;
    logic       q_empty;
    logic       push;
    logic       pop;
    t_frame_sum front_sum;
    t_frame_sum q_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_READY:    r_cfg.ready    <= i_cfg_data[0];
                REG_SLAVE:    r_cfg.slave    <= i_cfg_data[7:0];
                REG_FUNCTION: r_cfg.func     <= i_cfg_data[7:0];
                REG_WORD_A:   r_cfg.word_a   <= i_cfg_data;
                REG_WORD_B:   r_cfg.word_b   <= i_cfg_data;
                REG_WORD_C:   r_cfg.word_c   <= i_cfg_data;
                REG_QUANTITY: r_cfg.quantity <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // The front part folds each byte into the running frame state and
    // pushes a summary of the frame when its final byte arrives.
    mrrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_sum       (front_sum)
    );

    mrrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_sum),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_sum)
    );

    // The back part runs the ordered checks on a summary and registers
    // the verdict for the output channel.
    mrrc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (q_empty),
        .i_sum            (q_sum),
        .o_pop            (pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_exception_code (o_exception_code),
        .o_frame_length   (o_frame_length)
    );

endmodule
